// ===== sv/esp_pkg.sv =====
// Package: shared types and constants for the encoder speed and position tracker.
package esp_pkg;

    // Item codes.
    localparam logic [1:0] OP_OVF    = 2'd0;
    localparam logic [1:0] OP_CAP    = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // Register indexes.
    localparam logic [2:0] CFG_TICKS_PER_OVF = 3'd0;
    localparam logic [2:0] CFG_TICK_RATE     = 3'd1;
    localparam logic [2:0] CFG_FREQ_LOW      = 3'd2;
    localparam logic [2:0] CFG_FREQ_HIGH     = 3'd3;
    localparam logic [2:0] CFG_EDGES_PER_STEP = 3'd4;
    localparam logic [2:0] CFG_CONTRACT_LIM  = 3'd5;
    localparam logic [2:0] CFG_EXTEND_LIM    = 3'd6;
    localparam logic [2:0] CFG_INIT_DIR      = 3'd7;

    // Register reset values.
    localparam logic [16:0] RST_TICKS_PER_OVF  = 17'd65532;
    localparam logic [26:0] RST_TICK_RATE      = 27'd1000000;
    localparam logic [15:0] RST_FREQ_LOW       = 16'd10;
    localparam logic [15:0] RST_FREQ_HIGH      = 16'd1200;
    localparam logic [7:0]  RST_EDGES_PER_STEP = 8'd1;
    localparam logic [31:0] RST_CONTRACT_LIM   = 32'd1000;
    localparam logic [31:0] RST_EXTEND_LIM     = 32'd0;
    localparam logic        RST_INIT_DIR       = 1'b1;

    // Divider geometry.
    localparam int         DIV_W      = 32;
    localparam int         ITER_W     = 6;
    localparam int         RATE_W     = 27;
    localparam logic [5:0] FREQ_ITERS = 6'd27;

    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;     // quotient bits to produce
        logic [DIV_W-1:0]  dividend;  // left aligned
        logic [DIV_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/encoder_speed_position_tracker_top.sv =====
// Top level: encoder period capture, frequency measurement and position tracking.
// Timer overflow and capture-edge items are absorbed in the cycle they are
// accepted. A sample request runs a short sequence: one 32x17 multiply for the
// overflow ticks, one add for the capture difference, then two divisions on a
// shared restoring divider that makes one quotient bit per cycle: 27 bits for
// tick_rate_hz / ticks and EDGE_COUNT_BITS bits for edge_count / edges_per_step.
// The frequency division is skipped when the elapsed tick count is zero.
// The input is stalled from a sample's acceptance until its result is loaded
// into the output register; a result waiting there does not block overflow or
// capture items. frequency_hz is zero when ticks is zero or the quotient lies
// outside [freq_low, freq_high]. Position wraps modulo 2^32; at the limits the
// wanted direction turns (extend limit checked first and wins). The start
// direction register is accepted but has no visible effect: reset restores it
// to extend, and that is what the wanted direction loads. Registers are
// written through a plain write port with no read-back; the user must write
// them only while the block is idle, and the block does not enforce this.
module encoder_speed_position_tracker_top
    import esp_pkg::*;
#(
    parameter int TIMER_BITS      = 16,
    parameter int EDGE_COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // register write port
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_opcode,
    input  logic [TIMER_BITS-1:0] i_capture_value,
    input  logic                  i_chan_b,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_frequency_hz,
    output logic signed [31:0]    o_position,
    output logic                  o_moving_direction,
    output logic                  o_wanted_direction
);

    localparam int ECB_PAD = DIV_W - EDGE_COUNT_BITS;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_ADD    = 9'b000000100,
        S_FSTART = 9'b000001000,
        S_FWAIT  = 9'b000010000,
        S_SSTART = 9'b000100000,
        S_SWAIT  = 9'b001000000,
        S_LIM    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [16:0]        r_tpo;
    logic [26:0]        r_rate;
    logic [15:0]        r_flow;
    logic [15:0]        r_fhigh;
    logic [7:0]         r_eps;
    logic signed [31:0] r_clim;
    logic signed [31:0] r_elim;

    // tracking state
    logic [31:0]                r_ovf_cnt;
    logic [TIMER_BITS-1:0]      r_cap_prev, r_cap_last;
    logic [31:0]                r_ovf_prev, r_ovf_last;
    logic                       r_chb_last;
    logic [EDGE_COUNT_BITS-1:0] r_edge_cnt;
    logic signed [31:0]         r_pos;
    logic                       r_wdir;
    logic                       r_mdir;

    // sample working registers
    logic [31:0] r_ticks;
    logic [15:0] r_freq;

    // output register
    logic               r_out_valid;
    logic [15:0]        r_out_freq;
    logic signed [31:0] r_out_pos;
    logic               r_out_mdir;
    logic               r_out_wdir;

    logic        w_in_acc;
    logic        w_out_load;
    logic [48:0] w_prod;
    logic [31:0] w_cap_diff;
    logic [31:0] w_steps;
    logic [31:0] w_new_pos;
    logic [7:0]  w_eps;

    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    assign w_prod     = {17'b0, DIV_W'(r_ovf_last - r_ovf_prev)} * {32'b0, r_tpo};
    assign w_cap_diff = 32'(r_cap_last) - 32'(r_cap_prev);
    assign w_eps      = (r_eps == 8'd0) ? 8'd1 : r_eps;
    assign w_steps    = w_div_rsp.quotient;
    assign w_new_pos  = r_chb_last ? 32'(r_pos) + w_steps : 32'(r_pos) - w_steps;

    // shared divider request
    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.iters    = FREQ_ITERS;
        w_div_req.dividend = {r_rate, (DIV_W - RATE_W)'(0)};
        w_div_req.divisor  = r_ticks;
        if (r_state == S_FSTART) begin
            w_div_req.start = (r_ticks != 32'd0);
        end else if (r_state == S_SSTART) begin
            w_div_req.start    = 1'b1;
            w_div_req.iters    = ITER_W'(EDGE_COUNT_BITS);
            w_div_req.dividend = DIV_W'(r_edge_cnt) << ECB_PAD;
            w_div_req.divisor  = {24'b0, w_eps};
        end else if (r_state == S_SWAIT) begin
            // divisor is held for the whole step division
            w_div_req.divisor  = {24'b0, w_eps};
        end
    end

    esp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_in_acc && i_opcode == OP_SAMPLE) n_state = S_MUL;
            S_MUL:    n_state = S_ADD;
            S_ADD:    n_state = S_FSTART;
            S_FSTART: n_state = (r_ticks != 32'd0) ? S_FWAIT : S_SSTART;
            S_FWAIT:  if (w_div_rsp.done) n_state = S_SSTART;
            S_SSTART: n_state = S_SWAIT;
            S_SWAIT:  if (w_div_rsp.done) n_state = S_LIM;
            S_LIM:    n_state = S_OUT;
            S_OUT:    if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpo   <= RST_TICKS_PER_OVF;
            r_rate  <= RST_TICK_RATE;
            r_flow  <= RST_FREQ_LOW;
            r_fhigh <= RST_FREQ_HIGH;
            r_eps   <= RST_EDGES_PER_STEP;
            r_clim  <= RST_CONTRACT_LIM;
            r_elim  <= RST_EXTEND_LIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TICKS_PER_OVF:  r_tpo   <= i_cfg_data[16:0];
                CFG_TICK_RATE:      r_rate  <= i_cfg_data[26:0];
                CFG_FREQ_LOW:       r_flow  <= i_cfg_data[15:0];
                CFG_FREQ_HIGH:      r_fhigh <= i_cfg_data[15:0];
                CFG_EDGES_PER_STEP: r_eps   <= i_cfg_data[7:0];
                CFG_CONTRACT_LIM:   r_clim  <= i_cfg_data;
                CFG_EXTEND_LIM:     r_elim  <= i_cfg_data;
                // start direction: reset restores it before it could be used
                CFG_INIT_DIR:       ;
                default: ;
            endcase
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_cnt  <= '0;
            r_cap_prev <= '0;
            r_cap_last <= '0;
            r_ovf_prev <= '0;
            r_ovf_last <= '0;
            r_chb_last <= 1'b0;
            r_edge_cnt <= '0;
            r_pos      <= '0;
            r_wdir     <= RST_INIT_DIR;
            r_mdir     <= 1'b0;
        end else begin
            if (w_in_acc && i_opcode == OP_OVF) begin
                r_ovf_cnt <= r_ovf_cnt + 32'd1;
            end
            if (w_in_acc && i_opcode == OP_CAP) begin
                r_cap_prev <= r_cap_last;
                r_cap_last <= i_capture_value;
                r_ovf_prev <= r_ovf_last;
                r_ovf_last <= r_ovf_cnt;
                r_chb_last <= i_chan_b;
                r_edge_cnt <= r_edge_cnt + 1'b1;
            end
            if (r_state == S_SWAIT && w_div_rsp.done) begin
                r_pos      <= w_new_pos;
                r_mdir     <= r_chb_last;
                r_edge_cnt <= '0;
            end
            if (r_state == S_LIM) begin
                // extend limit is checked first and wins
                priority if (r_pos <= r_elim) begin
                    r_wdir <= 1'b1;
                end else if (r_pos >= r_clim) begin
                    r_wdir <= 1'b0;
                end
            end
        end
    end

    // elapsed ticks and frequency
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_ticks <= w_prod[31:0];
        end else if (r_state == S_ADD) begin
            r_ticks <= r_ticks + w_cap_diff;
        end
        if (r_state == S_FSTART && r_ticks == 32'd0) begin
            r_freq <= '0;
        end else if (r_state == S_FWAIT && w_div_rsp.done) begin
            if (w_div_rsp.quotient > {16'b0, r_fhigh} || w_div_rsp.quotient < {16'b0, r_flow}) begin
                r_freq <= '0;
            end else begin
                r_freq <= w_div_rsp.quotient[15:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_out_freq <= r_freq;
            r_out_pos  <= r_pos;
            r_out_mdir <= r_mdir;
            r_out_wdir <= r_wdir;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_frequency_hz     = r_out_freq;
    assign o_position         = r_out_pos;
    assign o_moving_direction = r_out_mdir;
    assign o_wanted_direction = r_out_wdir;

`ifndef SYNTHESIS
    a_sample_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_opcode == OP_SAMPLE |=> o_in_stall)
        else $error("sample item did not block the input");
    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_opcode == OP_OVF |=> r_ovf_cnt == $past(r_ovf_cnt) + 32'd1)
        else $error("overflow item not counted");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_FWAIT || r_state == S_SWAIT))
        else $error("divider finished outside a wait state");
    a_edges_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LIM |-> r_edge_cnt == '0)
        else $error("edge count not cleared by sample");
`endif

endmodule

// ===== sv/esp_div.sv =====
// Shared restoring divider: one quotient bit per cycle.
module esp_div
    import esp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_q, n_q;
    logic [DIV_W:0]    w_trial;
    logic              w_fit;

    assign w_trial = {r_rem, r_q[DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, i_req.divisor});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = i_req.iters;
            n_rem  = '0;
            n_q    = i_req.dividend;
        end else if (r_busy) begin
            n_rem = w_fit ? DIV_W'(w_trial - {1'b0, i_req.divisor}) : w_trial[DIV_W-1:0];
            n_q   = {r_q[DIV_W-2:0], w_fit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start && i_req.iters != '0 |=> r_busy)
        else $error("divider did not start");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("divider restarted while busy");
`endif

endmodule
